[hw/rtl/acp_pkg.sv]
`default_nettype none
package acp_pkg;

   // Window of the current subfield
   localparam int MAX_SUBFIELD = 16;
   localparam int PTR_W        = $clog2(MAX_SUBFIELD);
   localparam int POS_W        = $clog2(MAX_SUBFIELD + 1);
   localparam int MAX_RESULTS  = 8;
   localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

   // Header / mask / command byte codes
   localparam logic [7:0] HDR_LEN_MASK = 8'h0F;
   localparam logic [7:0] HDR_ADAPTIVE = 8'h80;
   localparam logic [7:0] HDR_KEY      = 8'h20;
   localparam logic [7:0] CMD_CRYPTO   = 8'h2A;
   localparam logic [7:0] CMD_UPDATE   = 8'h46;
   localparam logic [7:0] KEY_NUM_MASK = 8'h1F;

   // File kinds
   localparam logic [1:0] FK_EF  = 2'd0;
   localparam logic [1:0] FK_DIR = 2'd1;
   localparam logic [1:0] FK_KEY = 2'd2;

   // Operations
   localparam logic [3:0] OP_SELECT       = 4'd0;
   localparam logic [3:0] OP_DELETE       = 4'd1;
   localparam logic [3:0] OP_CREATE       = 4'd2;
   localparam logic [3:0] OP_INVALIDATE   = 4'd3;
   localparam logic [3:0] OP_REHABILITATE = 4'd4;
   localparam logic [3:0] OP_LOCK         = 4'd5;
   localparam logic [3:0] OP_READ         = 4'd6;
   localparam logic [3:0] OP_UPDATE       = 4'd7;
   localparam logic [3:0] OP_WRITE        = 4'd8;
   localparam logic [3:0] OP_ERASE        = 4'd9;
   localparam logic [3:0] OP_CRYPTO       = 4'd10;
   localparam logic [3:0] OP_NONE         = 4'd15;

   // Methods
   localparam logic [2:0] METH_NONE  = 3'd0;
   localparam logic [2:0] METH_PIN   = 3'd1;
   localparam logic [2:0] METH_TERM  = 3'd2;
   localparam logic [2:0] METH_SM    = 3'd3;
   localparam logic [2:0] METH_KAUTH = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_LD_H, ST_LD_M, ST_DECIDE,
      ST_LD_CMD, ST_LD_KEY, ST_LD_PIN, ST_EMIT, ST_ADV, ST_FINISH
   } state_type;

   // Window read offset select
   typedef enum logic [2:0] {
      RD_HDR, RD_MASK, RD_CMD, RD_KEY, RD_PIN
   } rd_sel_type;

   typedef struct packed {
      logic       take;
      rd_sel_type rd_sel;
      logic       lat_h;
      logic       lat_m;
      logic       lat_cmd;
      logic       lat_sc;
      logic       lat_ref;
      logic       emit;
      logic       advance;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic pos_gt1;
      logic brk;
      logic stop;
      logic adv_stop;
      logic emit_ok;
      logic emit_last;
      logic out_free;
      logic pend_valid;
   } sts_type;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] meth;
      logic [7:0] key_ref;
   } entry_type;

   function automatic logic [3:0] map_op(input logic [1:0] kind, input logic [2:0] idx);
      logic [3:0] op;
      op = OP_NONE;
      if (kind == FK_DIR) begin
         case (idx)
            3'd0:    op = OP_DELETE;
            3'd1:    op = OP_CREATE;
            3'd2:    op = OP_CREATE;
            3'd3:    op = OP_INVALIDATE;
            3'd4:    op = OP_REHABILITATE;
            3'd5:    op = OP_LOCK;
            3'd6:    op = OP_DELETE;
            default: op = OP_NONE;
         endcase
      end else if (kind == FK_KEY) begin
         case (idx)
            3'd0:    op = OP_READ;
            3'd1:    op = OP_ERASE;
            3'd2:    op = OP_UPDATE;
            3'd3:    op = OP_INVALIDATE;
            3'd4:    op = OP_REHABILITATE;
            3'd6:    op = OP_ERASE;
            default: op = OP_NONE;
         endcase
      end else begin
         // elementary file table, also for the unused kind code
         case (idx)
            3'd0:    op = OP_READ;
            3'd1:    op = OP_UPDATE;
            3'd2:    op = OP_WRITE;
            3'd3:    op = OP_INVALIDATE;
            3'd4:    op = OP_REHABILITATE;
            3'd6:    op = OP_ERASE;
            default: op = OP_NONE;
         endcase
      end
      return op;
   endfunction

   function automatic logic [2:0] key_method(input logic [7:0] sc);
      logic [2:0] meth;
      case (sc[6:5])
         2'd0:    meth = METH_TERM;
         2'd1:    meth = METH_KAUTH;
         default: meth = METH_SM;
      endcase
      return meth;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/acp_req_if.sv]
`default_nettype none
interface acp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_buffer;
   logic [1:0] file_kind;

   modport source (output valid, output data_byte, output end_of_buffer, output file_kind,
                   input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, input file_kind,
                   output ready);
endinterface
`default_nettype wire

[hw/rtl/acp_rsp_if.sv]
`default_nettype none
interface acp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] operation;
   logic [2:0] method;
   logic [7:0] key_reference;
   logic       last_entry;

   modport source (output valid, output operation, output method, output key_reference,
                   output last_entry, input ready);
   modport sink   (input valid, input operation, input method, input key_reference,
                   input last_entry, output ready);
endinterface
`default_nettype wire

[hw/rtl/acp_ram.sv]
`default_nettype none
module acp_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[hw/rtl/acp_ctrl.sv]
`default_nettype none
module acp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output acp_pkg::cmd_type cmd,
   input  acp_pkg::sts_type sts
);
   import acp_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_SCAN;
         ST_SCAN:   state_in = sts.pos_gt1 ? ST_LD_H : ST_FINISH;
         ST_LD_H:   state_in = ST_LD_M;
         ST_LD_M:   state_in = ST_DECIDE;
         ST_DECIDE: state_in = (sts.brk || sts.stop) ? ST_FINISH : ST_LD_CMD;
         ST_LD_CMD: state_in = ST_LD_KEY;
         ST_LD_KEY: state_in = ST_LD_PIN;
         ST_LD_PIN: state_in = ST_EMIT;
         ST_EMIT:   if (sts.emit_ok && sts.emit_last) state_in = ST_ADV;
         ST_ADV:    state_in = sts.adv_stop ? ST_FINISH : ST_SCAN;
         ST_FINISH: if (sts.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.rd_sel = RD_HDR;
      req_ready  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         ST_SCAN:   cmd.rd_sel = RD_HDR;
         ST_LD_H: begin
            cmd.lat_h  = 1'b1;
            cmd.rd_sel = RD_MASK;
         end
         ST_LD_M:   cmd.lat_m = 1'b1;
         ST_DECIDE: cmd.rd_sel = RD_CMD;
         ST_LD_CMD: begin
            cmd.lat_cmd = 1'b1;
            cmd.rd_sel  = RD_KEY;
         end
         ST_LD_KEY: begin
            cmd.lat_sc = 1'b1;
            cmd.rd_sel = RD_PIN;
         end
         ST_LD_PIN: cmd.lat_ref = 1'b1;
         ST_EMIT:   cmd.emit = 1'b1;
         ST_ADV:    cmd.advance = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         default:   cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !sts.pend_valid)
      else $error("pending entry left over while idle");

   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_SCAN)
      else $error("accepted byte did not start a scan");

   a_emit_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !sts.emit_ok) |=> state_ff == ST_EMIT)
      else $error("left emit while an entry was blocked");
endmodule
`default_nettype wire

[hw/rtl/acp_dp.sv]
`default_nettype none
module acp_dp (
   input  logic             clock,
   input  logic             reset,
   input  acp_pkg::cmd_type cmd,
   output acp_pkg::sts_type sts,
   input  logic [7:0]       req_data_byte,
   input  logic             req_end_of_buffer,
   input  logic [1:0]       req_file_kind,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [3:0]       rsp_operation,
   output logic [2:0]       rsp_method,
   output logic [7:0]       rsp_key_reference,
   output logic             rsp_last_entry
);
   import acp_pkg::*;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       kept_ff, kept_in;
   logic             fin_ff, fin_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       h_ff, h_in;
   logic [7:0]       m_ff, m_in;
   logic [7:0]       cmd_byte_ff, cmd_byte_in;
   logic [7:0]       sc_ff, sc_in;
   logic [7:0]       ref_ff, ref_in;
   logic [2:0]       meth_ff, meth_in;
   logic [2:0]       bit_ff, bit_in;
   logic [CNT_W-1:0] n_ff, n_in;
   entry_type        pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   entry_type        out_ff, out_in;
   logic             out_last_ff, out_last_in;
   logic             out_valid_ff, out_valid_in;

   // window memory, circular from head_ff
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic [PTR_W-1:0] rd_addr;
   logic [PTR_W-1:0] rd_off;
   logic [7:0]       rd_data;

   acp_ram #(.Width(8), .Depth(MAX_SUBFIELD)) u_window (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // subfield decode from latched header and mask
   logic             adapt_w, key_w, pin_w;
   logic [2:0]       parm3;
   logic [POS_W-1:0] len_w, parm_w, pin_at_w, need0, need_a, need_b, need_w;
   logic [POS_W-1:0] full_w, step_w, key_add;

   always_comb begin
      adapt_w = |(h_ff & HDR_ADAPTIVE);
      key_w   = |(h_ff & HDR_KEY);
      len_w   = POS_W'(h_ff & HDR_LEN_MASK);
      key_add = POS_W'(key_w);
      parm3   = 3'd1 + {2'b0, m_ff[6]} + {2'b0, m_ff[5]} + {2'b0, m_ff[4]}
              + {2'b0, m_ff[3]};
      parm_w  = POS_W'(parm3);
      if (adapt_w) begin
         pin_w    = len_w > (POS_W'(1) + parm_w + key_add);
         pin_at_w = parm_w + POS_W'(2);
         need0    = POS_W'(2);
      end else begin
         pin_w    = len_w > (POS_W'(1) + key_add);
         pin_at_w = POS_W'(2);
         need0    = POS_W'(1);
      end
      need_a = (key_w && len_w > need0) ? len_w : need0;
      need_b = (pin_w && pin_at_w > need_a) ? pin_at_w : need_a;
      need_w = (len_w != '0 && (len_w - POS_W'(1)) > need_b) ? len_w - POS_W'(1) : need_b;
      full_w = (need_w > len_w) ? need_w : len_w;
      step_w = len_w + POS_W'(1);
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_HDR:  rd_off = '0;
         RD_MASK: rd_off = PTR_W'(1);
         RD_CMD:  rd_off = PTR_W'(2);
         RD_KEY:  rd_off = len_w[PTR_W-1:0];
         RD_PIN:  rd_off = pin_at_w[PTR_W-1:0];
         default: rd_off = '0;
      endcase
   end

   assign rd_addr = head_ff + rd_off;
   assign wr_addr = head_ff + pos_ff[PTR_W-1:0];
   assign wr_en   = cmd.take && (pos_ff < POS_W'(MAX_SUBFIELD));

   // entry generation
   logic [3:0] adapt_op, map_op_w;
   logic       hit, want, slot_free, can_push, push, flush;
   entry_type  new_entry;
   logic [2:0] meth_n;
   logic [7:0] ref_n;

   always_comb begin
      if (cmd_byte_ff == CMD_CRYPTO) begin
         adapt_op = OP_CRYPTO;
      end else if (cmd_byte_ff == CMD_UPDATE) begin
         adapt_op = OP_UPDATE;
      end else begin
         adapt_op = OP_SELECT;
      end
      map_op_w          = map_op(kind_ff, bit_ff);
      hit               = adapt_w || (m_ff[bit_ff] && map_op_w != OP_NONE);
      want              = hit && (n_ff < CNT_W'(MAX_RESULTS));
      slot_free         = !out_valid_ff || rsp_ready;
      can_push          = !pend_valid_ff || slot_free;
      push              = cmd.emit && want && can_push;
      flush             = cmd.finish && can_push;
      new_entry.op      = adapt_w ? adapt_op : map_op_w;
      new_entry.meth    = meth_ff;
      new_entry.key_ref = ref_ff;
   end

   // method and key reference: key byte first, pin byte overrides
   always_comb begin
      ref_n  = kept_ff;
      meth_n = METH_NONE;
      if (key_w) begin
         meth_n = key_method(sc_ff);
         ref_n  = sc_ff & KEY_NUM_MASK;
      end
      if (pin_w) begin
         ref_n  = rd_data;
         meth_n = METH_PIN;
      end
   end

   always_comb begin
      head_in       = head_ff;
      pos_in        = pos_ff;
      kept_in       = kept_ff;
      fin_in        = fin_ff;
      kind_in       = kind_ff;
      h_in          = h_ff;
      m_in          = m_ff;
      cmd_byte_in   = cmd_byte_ff;
      sc_in         = sc_ff;
      ref_in        = ref_ff;
      meth_in       = meth_ff;
      bit_in        = bit_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;

      if (cmd.take) begin
         fin_in  = req_end_of_buffer;
         kind_in = req_file_kind;
         if (wr_en) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
      if (cmd.lat_h)   h_in        = rd_data;
      if (cmd.lat_m)   m_in        = rd_data;
      if (cmd.lat_cmd) cmd_byte_in = rd_data;
      if (cmd.lat_sc)  sc_in       = rd_data;
      if (cmd.lat_ref) begin
         ref_in  = ref_n;
         meth_in = meth_n;
         kept_in = ref_n;
         bit_in  = '0;
      end
      if (cmd.emit && sts.emit_ok && !sts.emit_last) begin
         bit_in = bit_ff + 3'd1;
      end
      // pending entry moves to the output once its successor is known
      if ((push || flush) && pend_valid_ff) begin
         out_in       = pend_ff;
         out_last_in  = flush;
         out_valid_in = 1'b1;
      end
      if (push) begin
         pend_in       = new_entry;
         pend_valid_in = 1'b1;
         n_in          = n_ff + CNT_W'(1);
      end
      if (cmd.advance && !sts.adv_stop) begin
         head_in = head_ff + step_w[PTR_W-1:0];
         pos_in  = pos_ff - step_w;
      end
      if (flush) begin
         pend_valid_in = 1'b0;
         n_in          = '0;
         if (fin_ff) begin
            pos_in  = '0;
            kept_in = '0;
         end
      end
   end

   always_comb begin
      sts.pos_gt1    = pos_ff > POS_W'(1);
      sts.brk        = !fin_ff && (pos_ff <= full_w);
      sts.stop       = fin_ff && (need_w >= pos_ff);
      sts.adv_stop   = step_w > pos_ff;
      sts.emit_ok    = !want || can_push;
      sts.emit_last  = adapt_w || (bit_ff == 3'd7);
      sts.out_free   = can_push;
      sts.pend_valid = pend_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         pos_ff        <= '0;
         kept_ff       <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         pos_ff        <= pos_in;
         kept_ff       <= kept_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff      <= fin_in;
      kind_ff     <= kind_in;
      h_ff        <= h_in;
      m_ff        <= m_in;
      cmd_byte_ff <= cmd_byte_in;
      sc_ff       <= sc_in;
      ref_ff      <= ref_in;
      meth_ff     <= meth_in;
      bit_ff      <= bit_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_operation     = out_ff.op;
   assign rsp_method        = out_ff.meth;
   assign rsp_key_reference = out_ff.key_ref;
   assign rsp_last_entry    = out_last_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_SUBFIELD))
      else $error("window fill beyond its depth");

   a_cap_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_RESULTS))
      else $error("entry count beyond the cap");

   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (flush && fin_ff) |=> (pos_ff == '0 && kept_ff == '0))
      else $error("final byte did not clear the window");
endmodule
`default_nettype wire

[hw/rtl/access_condition_parser.sv]
// Access-condition parser.
// req_chan (sink): one attribute byte per word, with end_of_buffer on the final
//   byte and file_kind selecting the operation table for simple coding.
// rsp_chan (source): access-control entries (operation, method, key_reference);
//   last_entry is set on the final entry caused by one input byte.
// Bytes are taken one at a time: req_chan.ready is high only while the parser
//   waits for a byte. Each byte is scanned; if the window holds at least two
//   bytes, header and mask are fetched, and a complete subfield is decoded by
//   fetching command, key and pin bytes and emitting entries (one for adaptive
//   coding, one mask bit per cycle for simple coding unless rsp_chan stalls).
// The subfield window is a 16 x 8 RAM with one registered read port; a decoded
//   subfield needs five sequential reads.
// Entries pass through a one-word hold register and a one-word output
//   register; when rsp_chan stalls, the parser waits with both full and resumes
//   without loss. At most 8 entries leave per input byte.
// Reset (synchronous) empties the window and clears the carried key reference;
//   no clearing pass is needed. The final byte of a buffer does the same.
`default_nettype none
module access_condition_parser (
   input  logic      clock,
   input  logic      reset,
   acp_req_if.sink   req_chan,
   acp_rsp_if.source rsp_chan
);
   import acp_pkg::*;

   cmd_type cmd;     // controller -> datapath
   sts_type sts;     // datapath -> controller
   logic    req_ready;

   acp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   acp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_data_byte     (req_chan.data_byte),
      .req_end_of_buffer (req_chan.end_of_buffer),
      .req_file_kind     (req_chan.file_kind),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_operation     (rsp_chan.operation),
      .rsp_method        (rsp_chan.method),
      .rsp_key_reference (rsp_chan.key_reference),
      .rsp_last_entry    (rsp_chan.last_entry)
   );

   assign req_chan.ready = req_ready;
endmodule
`default_nettype wire

[dv/access_condition_parser_tb.sv]
module access_condition_parser_tb;
   import acp_pkg::*;

   // Stimulus sizing and run limits
   localparam int ITEM_TARGET    = 320;   // attribute bytes in the whole run
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
   localparam int DRAIN_CYCLES   = 64;    // idle run-out once both queues are empty

   // Idle percentages per phase, index = phase (0: slow sink, 1: slow source, 2: none)
   localparam logic [2:0][6:0] TX_IDLE_PCT = {7'd0, 7'd87, 7'd9};
   localparam logic [2:0][6:0] RX_IDLE_PCT = {7'd0, 7'd9, 7'd87};

   // Simple-coding operation tables, index = operation mask bit
   localparam logic [7:0][3:0] EF_OPS = {OP_NONE, OP_ERASE, OP_NONE, OP_REHABILITATE,
                                         OP_INVALIDATE, OP_WRITE, OP_UPDATE, OP_READ};
   localparam logic [7:0][3:0] DIR_OPS = {OP_NONE, OP_DELETE, OP_LOCK, OP_REHABILITATE,
                                          OP_INVALIDATE, OP_CREATE, OP_CREATE, OP_DELETE};
   localparam logic [7:0][3:0] KEY_OPS = {OP_NONE, OP_ERASE, OP_NONE, OP_REHABILITATE,
                                          OP_INVALIDATE, OP_UPDATE, OP_ERASE, OP_READ};

   // One input word; hold makes the source wait until every entry has drained
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
      logic [1:0] file_kind;
      logic       hold;
   } attr_word_type;

   typedef struct packed {
      logic [3:0] operation;
      logic [2:0] method;
      logic [7:0] key_reference;
      logic       last_entry;
   } acl_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acp_req_if req_chan ();
   acp_rsp_if rsp_chan ();

   access_condition_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   attr_word_type attr_bytes [$];        // words still to send
   acl_entry_type expected_entries [$];  // entries predicted, not yet seen

   // Predictor state: subfield window, fill level, carried key reference, halt flag
   logic [7:0]  window [MAX_SUBFIELD];
   int unsigned window_fill = 0;
   logic [7:0]  carried_key_ref = '0;
   bit          parse_halted = 1'b0;

   int mismatches = 0;
   int entries_checked = 0;
   int bytes_sent = 0;
   int total_bytes = 0;
   int buffers_made = 0;
   int adaptive_decodes = 0;
   int simple_decodes = 0;
   int parses_cut = 0;
   int capped_bytes = 0;
   int quiet_cycles = 0;
   logic [1:0] idle_phase = 2'd0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 50) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Walk the window the same way the parser does and queue the entries that
   // this byte releases. Two subfields can complete on one byte when a short
   // adaptive subfield reads into the next one.
   function automatic void predict_entries(input attr_word_type w);
      acl_entry_type step_entries [$];
      acl_entry_type e;
      logic [7:0] hdr, mask, sc, key_ref;
      logic [7:0][3:0] ops;
      logic [3:0] op;
      logic [2:0] meth;
      int unsigned len, parm, pin_at, need, full;
      int count, i;
      bit adaptive, has_key, has_pin;

      // unknown kind code falls back to the elementary-file table
      ops = (w.file_kind == FK_DIR) ? DIR_OPS : (w.file_kind == FK_KEY) ? KEY_OPS : EF_OPS;
      if (!parse_halted && window_fill < MAX_SUBFIELD) begin
         window[window_fill] = w.data_byte;
         window_fill++;
      end

      while (!parse_halted && window_fill > 1) begin
         hdr      = window[0];
         mask     = window[1];
         len      = int'(hdr & HDR_LEN_MASK);
         adaptive = |(hdr & HDR_ADAPTIVE);
         has_key  = |(hdr & HDR_KEY);
         need     = 1;
         if (adaptive) begin
            // command byte plus one parameter byte per set mask bit 6..3
            parm    = 1 + mask[6] + mask[5] + mask[4] + mask[3];
            has_pin = len > 1 + parm + has_key;
            pin_at  = 2 + parm;
            need    = 2;
         end else begin
            count   = int'(len) - 1 - int'(has_key);
            has_pin = count > 0;
            pin_at  = 2;
         end
         if (has_key && len > need) need = len;
         if (has_pin && pin_at > need) need = pin_at;
         if (len > 0 && len - 1 > need) need = len - 1;

         if (!w.end_of_buffer) begin
            full = (need > len) ? need : len;
            if (window_fill <= full) break;
         end else if (need >= window_fill) begin
            // final byte: subfield reads past the buffer end
            parse_halted = 1'b1;
            parses_cut++;
            break;
         end

         meth    = METH_NONE;
         key_ref = carried_key_ref;
         if (has_key) begin
            sc = window[len];
            case (sc[6:5])
               2'd0:    meth = METH_TERM;
               2'd1:    meth = METH_KAUTH;
               default: meth = METH_SM;
            endcase
            key_ref = sc & KEY_NUM_MASK;
         end
         if (has_pin) begin
            key_ref = window[pin_at];
            meth    = METH_PIN;
         end
         carried_key_ref = key_ref;

         if (adaptive) begin
            op = (window[2] == CMD_CRYPTO) ? OP_CRYPTO :
                 (window[2] == CMD_UPDATE) ? OP_UPDATE : OP_SELECT;
            e = '{operation: op, method: meth, key_reference: key_ref, last_entry: 1'b0};
            step_entries.push_back(e);
            adaptive_decodes++;
         end else begin
            for (i = 0; i < 8; i++) begin
               if (mask[i] && ops[i] != OP_NONE) begin
                  e = '{operation: ops[i], method: meth, key_reference: key_ref,
                        last_entry: 1'b0};
                  step_entries.push_back(e);
               end
            end
            simple_decodes++;
         end

         // short last subfield: decoded, then nothing more is parsed
         if (len + 1 > window_fill) begin
            parse_halted = 1'b1;
            parses_cut++;
            break;
         end
         for (i = 0; i + len + 1 < window_fill; i++) window[i] = window[i + len + 1];
         window_fill -= len + 1;
      end

      while (step_entries.size() > MAX_RESULTS) void'(step_entries.pop_back());
      if (step_entries.size() != 0) begin
         step_entries[step_entries.size() - 1].last_entry = 1'b1;
         if (step_entries.size() == MAX_RESULTS) capped_bytes++;
      end
      foreach (step_entries[k]) expected_entries.push_back(step_entries[k]);

      if (w.end_of_buffer) begin
         window_fill     = 0;
         carried_key_ref = '0;
         parse_halted    = 1'b0;
      end
   endfunction

   function automatic void push_word(input logic [7:0] b, input bit fin, input logic [1:0] kind,
                                     input bit hold);
      attr_word_type w;
      w.data_byte     = b;
      w.end_of_buffer = fin;
      w.file_kind     = kind;
      w.hold          = hold;
      attr_bytes.push_back(w);
   endfunction

   // Directed buffer: n bytes packed first-byte-most-significant; the source
   // drains all pending entries before its first byte.
   task automatic add_buffer(input logic [1:0] kind, input int n, input logic [63:0] packed_bytes);
      int k;
      for (k = n - 1; k >= 0; k--) push_word(packed_bytes[8*k +: 8], k == 0, kind, k == n - 1);
      buffers_made++;
   endtask

   // Random buffer: mostly chains of well-formed subfields with random content,
   // some truncated or with a trailing lone byte, some plain noise.
   task automatic add_random_buffer();
      logic [7:0] bytes [$];
      logic [7:0] mask, cmd;
      logic [1:0] kind;
      int shape, n_sub, len, parm, s, k;
      bit adaptive, key, pin, hold;

      kind  = ($urandom_range(7) == 0) ? 2'd3 : 2'($urandom_range(2));
      shape = $urandom_range(9);
      hold  = ($urandom_range(7) == 0);
      if (shape == 9) begin
         repeat ($urandom_range(1, 20)) bytes.push_back(8'($urandom));
      end else begin
         n_sub = $urandom_range(1, 3);
         for (s = 0; s < n_sub; s++) begin
            adaptive = ($urandom_range(2) == 0);
            key      = 1'($urandom_range(1));
            mask     = 8'($urandom);
            if (adaptive) begin
               parm = 1 + mask[6] + mask[5] + mask[4] + mask[3];
               pin  = 1'($urandom_range(1));
               len  = 1 + parm + pin + key;
            end else begin
               // long subfields now and then fill the whole window
               len = ($urandom_range(7) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 4);
            end
            bytes.push_back({adaptive, 1'($urandom), key, 1'($urandom), 4'(len)});
            bytes.push_back(mask);
            for (k = 2; k <= len; k++) begin
               cmd = 8'($urandom);
               if (adaptive && k == 2) begin
                  case ($urandom_range(2))
                     0:       cmd = CMD_CRYPTO;
                     1:       cmd = CMD_UPDATE;
                     default: cmd = 8'($urandom);
                  endcase
               end
               bytes.push_back(cmd);
            end
         end
         if (shape == 7) begin
            repeat ($urandom_range(1, 3)) if (bytes.size() > 1) void'(bytes.pop_back());
         end else if (shape == 8) begin
            bytes.push_back(8'($urandom));
         end
      end
      for (k = 0; k < bytes.size(); k++)
         push_word(bytes[k], k == bytes.size() - 1, kind, hold && k == 0);
      buffers_made++;
   endtask

   // Source side: drives the head of attr_bytes, predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_entries(attr_bytes.pop_front());
            bytes_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (attr_bytes.size() != 0 && !(attr_bytes[0].hold && expected_entries.size() != 0)
                && $urandom_range(99) >= TX_IDLE_PCT[idle_phase]) begin
               req_chan.valid         <= 1'b1;
               req_chan.data_byte     <= attr_bytes[0].data_byte;
               req_chan.end_of_buffer <= attr_bytes[0].end_of_buffer;
               req_chan.file_kind     <= attr_bytes[0].file_kind;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         idle_phase <= (bytes_sent * 3 >= total_bytes * 2) ? 2'd2 :
                       (bytes_sent * 3 >= total_bytes)     ? 2'd1 : 2'd0;
      end
   end

   // Sink side: random backpressure, compare each word with the oldest prediction.
   always @(posedge clock) begin
      acl_entry_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_entries.size() == 0) begin
               report_mismatch($sformatf("unexpected entry op %0d method %0d key %0d last %0d",
                  rsp_chan.operation, rsp_chan.method, rsp_chan.key_reference,
                  rsp_chan.last_entry));
            end else begin
               want = expected_entries.pop_front();
               if (rsp_chan.operation !== want.operation)
                  report_mismatch($sformatf("entry %0d operation %0d, expected %0d",
                     entries_checked, rsp_chan.operation, want.operation));
               if (rsp_chan.method !== want.method)
                  report_mismatch($sformatf("entry %0d method %0d, expected %0d",
                     entries_checked, rsp_chan.method, want.method));
               if (rsp_chan.key_reference !== want.key_reference)
                  report_mismatch($sformatf("entry %0d key_reference %0d, expected %0d",
                     entries_checked, rsp_chan.key_reference, want.key_reference));
               if (rsp_chan.last_entry !== want.last_entry)
                  report_mismatch($sformatf("entry %0d last_entry %0d, expected %0d",
                     entries_checked, rsp_chan.last_entry, want.last_entry));
               entries_checked++;
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= RX_IDLE_PCT[idle_phase]);
      end
   end

   // Watchdog: cycles since any word moved on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      req_chan.valid         = 1'b0;
      req_chan.data_byte     = '0;
      req_chan.end_of_buffer = 1'b0;
      req_chan.file_kind     = FK_EF;
      rsp_chan.ready         = 1'b0;

      // Directed buffers
      add_buffer(FK_EF,  1, 64'h00);              // lone trailing byte, ignored
      add_buffer(2'd3,   2, 64'h01FF);            // unknown kind, full mask, no key
      add_buffer(FK_DIR, 3, 64'h22FF7F);          // key byte: secure messaging, key 31
      add_buffer(FK_KEY, 6, 64'h235B553F0102);    // pin beats key, then carried reference
      add_buffer(FK_EF,  4, 64'h83002AAB);        // adaptive crypto with pin
      add_buffer(FK_EF,  4, 64'hA300461E);        // adaptive update, terminal key
      add_buffer(FK_DIR, 3, 64'h80017F);          // short adaptive reads past, eight entries
      add_buffer(FK_EF,  2, 64'h05FF);            // subfield runs past the end

      while (attr_bytes.size() < ITEM_TARGET) add_random_buffer();
      total_bytes = attr_bytes.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while ((attr_bytes.size() != 0 || expected_entries.size() != 0)
             && quiet_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      if (quiet_cycles >= WATCHDOG_LIMIT)
         report_mismatch($sformatf("no word moved for %0d cycles, %0d bytes unsent, %0d entries due",
            quiet_cycles, attr_bytes.size(), expected_entries.size()));
      else
         repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run: %0d attribute bytes in %0d buffers, %0d entries checked",
               bytes_sent, buffers_made, entries_checked);
      $display("Decoded %0d adaptive / %0d simple subfields, %0d parses cut short, %0d bytes at cap",
               adaptive_decodes, simple_decodes, parses_cut, capped_bytes);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
